@@ rtl/key_value_table_insert_update_remove_core_assert.svh @@
// Assertion macros used by the checker file kvt_checker.sv.
`ifndef KEY_VALUE_TABLE_INSERT_UPDATE_REMOVE_CORE_ASSERT_SVH
`define KEY_VALUE_TABLE_INSERT_UPDATE_REMOVE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define KVT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define KVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/kvt_pkg.sv @@
package kvt_pkg;

  // Operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [2:0] STAT_INSERTED  = 3'd0;
  localparam logic [2:0] STAT_UPDATED   = 3'd1;
  localparam logic [2:0] STAT_REMOVED   = 3'd2;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
  localparam logic [2:0] STAT_FULL      = 3'd4;
  localparam logic [2:0] STAT_CLEARED   = 3'd5;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [4:0] entry_count;
  } out_item_t;

  // Contents of one table cell
  typedef struct packed {
    logic               valid;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } kv_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic               match_en;
    logic               update_en;
    logic               insert_en;
    logic               shift_en;
    logic               clear_en;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } cmd_t;

endpackage

@@ rtl/key_value_table_insert_update_remove_core.sv @@
// Associative key/value table, up to ENTRIES pairs of signed 32-bit keys and values.
// Input channel in_valid/in_ready/in_item carries one operation per item:
// add-or-update, remove by key, or clear. Every item yields exactly one result
// on out_valid/out_ready/out_item: a status code and the entry count after the op.
// Each item passes a match step, which compares the key in all cells at once and
// registers the hits, and then an apply step, which applies the change and loads
// the result into the output register. The next item can be accepted in the same
// cycle as the last one's apply step, but never during its match step.
// Entries are kept packed at the low end of the row; insert lands in the first
// free cell, remove shifts every cell above the hit down by one, handed from
// neighbor to neighbor.
// Reset (rst_n low, synchronous) empties the table and drops any pending item.
// When the receiver stalls, the result sits in the output register; the next
// item may still be accepted and matched, but its apply step waits until the
// output register frees up, and no further item is taken meanwhile.
module key_value_table_insert_update_remove_core
  import kvt_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MATCH = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]       state_r, state_nxt;
  in_item_t         item_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r;
  logic [2:0]       status;

  logic accept;
  logic out_free;
  logic apply_go;
  logic hit;
  logic full;
  cmd_t cmd;

  kv_t  cell_entry [ENTRIES];
  logic seen [ENTRIES+1];

  assign out_free = !out_valid_r || out_ready;
  assign apply_go = (state_r == S_APPLY) && out_free;
  assign in_ready = (state_r == S_IDLE) || apply_go;
  assign accept   = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The hit chain leaves the top cell as "key present anywhere".
  assign hit  = seen[ENTRIES];
  assign full = (count_r == CNT_W'(ENTRIES));

  // Command to the row
  always_comb begin
    cmd.match_en  = (state_r == S_MATCH);
    cmd.update_en = apply_go && (item_r.op == OP_ADD) && hit;
    cmd.insert_en = apply_go && (item_r.op == OP_ADD) && !hit && !full;
    cmd.shift_en  = apply_go && (item_r.op == OP_REMOVE) && hit;
    cmd.clear_en  = apply_go && (item_r.op == OP_CLEAR);
    cmd.key       = item_r.key;
    cmd.value     = item_r.value;
  end

  // Row of cells; seen ripples upward from cell 0
  assign seen[0] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kv_t  upper;
    logic lower_valid;

    if (i == ENTRIES - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = cell_entry[i+1];
    end

    if (i == 0) begin : g_bot
      assign lower_valid = 1'b1;
    end else begin : g_up
      assign lower_valid = cell_entry[i-1].valid;
    end

    kvt_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .upper       (upper),
      .lower_valid (lower_valid),
      .seen_in     (seen[i]),
      .seen_out    (seen[i+1]),
      .entry       (cell_entry[i])
    );
  end

  // Status of the op in the apply step
  always_comb begin
    unique case (item_r.op)
      OP_ADD:    status = hit ? STAT_UPDATED : (full ? STAT_FULL : STAT_INSERTED);
      OP_REMOVE: status = hit ? STAT_REMOVED : STAT_NOT_FOUND;
      OP_CLEAR:  status = STAT_CLEARED;
      default:   status = STAT_NOT_FOUND;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear_en) begin
      count_nxt = '0;
    end else if (cmd.insert_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.shift_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_MATCH;
      S_MATCH: state_nxt = S_APPLY;
      S_APPLY: begin
        if (apply_go) state_nxt = accept ? S_MATCH : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (apply_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    if (apply_go) begin
      out_item_r.status      <= status;
      out_item_r.entry_count <= 5'(count_nxt);
    end
  end

endmodule

@@ rtl/kvt_cell.sv @@
module kvt_cell
  import kvt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  input  kv_t  upper,
  input  logic lower_valid,
  input  logic seen_in,
  output logic seen_out,
  output kv_t  entry
);

  logic               valid_r, valid_nxt;
  logic               match_r, match_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic signed [31:0] value_r, value_nxt;

  // a hit here or in any lower cell
  assign seen_out = seen_in | match_r;

  assign entry.valid = valid_r;
  assign entry.key   = key_r;
  assign entry.value = value_r;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    match_nxt = cmd.match_en ? (valid_r && (key_r == cmd.key)) : match_r;
    if (cmd.clear_en) begin
      valid_nxt = 1'b0;
    end else if (cmd.shift_en && seen_out) begin
      // close the hole: take the upper neighbor's entry
      valid_nxt = upper.valid;
      key_nxt   = upper.key;
      value_nxt = upper.value;
    end else if (cmd.insert_en && !valid_r && lower_valid) begin
      // first free cell of the packed row
      valid_nxt = 1'b1;
      key_nxt   = cmd.key;
      value_nxt = cmd.value;
    end else if (cmd.update_en && match_r) begin
      value_nxt = cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

endmodule

@@ rtl/kvt_checker.sv @@
`include "key_value_table_insert_update_remove_core_assert.svh"

module kvt_checker
  import kvt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  `KVT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item), "result dropped or changed while stalled")

  `KVT_ASSERT_SAME(a_status_legal, clk, rst_n, out_valid, out_item.status <= STAT_CLEARED, "illegal status code")

  `KVT_ASSERT_SAME(a_clear_empty, clk, rst_n, out_valid && (out_item.status == STAT_CLEARED), out_item.entry_count == 5'd0, "clear left entries behind")

  `KVT_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "item taken in back-to-back cycles")

  `KVT_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, !out_valid || !$past(out_valid) || $past(out_ready) || $stable(out_item), "result lost after accept")

endmodule

bind key_value_table_insert_update_remove_core kvt_checker u_kvt_checker (.*);

@@ sim/kvt_table_checker.sv @@
`timescale 1ns / 100ps

// Keeps its own copy of the table, works out status and count for each
// accepted item, and checks each result against the oldest one owed.
module kvt_table_checker
  import kvt_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        mismatch_count,
  output int        results_owed
);

  logic               cell_used [ENTRIES];
  logic signed [31:0] cell_key  [ENTRIES];
  logic signed [31:0] cell_val  [ENTRIES];
  int                 live_count;
  int                 fail_total = 0;
  out_item_t          owed_q [$];

  // Apply one operation to the table copy; return the result it causes.
  function automatic out_item_t table_op(input in_item_t it);
    int        n;
    int        hit;
    int        spare;
    out_item_t res;
    hit   = -1;
    spare = -1;
    for (n = 0; n < ENTRIES; n++) begin
      if (cell_used[n] && cell_key[n] == it.key && hit < 0) hit = n;
      if (!cell_used[n] && spare < 0) spare = n;
    end
    case (it.op)
      OP_ADD: begin
        if (hit >= 0) begin
          cell_val[hit] = it.value;
          res.status = STAT_UPDATED;
        end else if (spare >= 0) begin
          cell_used[spare] = 1'b1;
          cell_key[spare]  = it.key;
          cell_val[spare]  = it.value;
          live_count++;
          res.status = STAT_INSERTED;
        end else begin
          res.status = STAT_FULL;
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          cell_used[hit] = 1'b0;
          if (live_count > 0) live_count--;
          res.status = STAT_REMOVED;
        end else begin
          res.status = STAT_NOT_FOUND;
        end
      end
      OP_CLEAR: begin
        for (n = 0; n < ENTRIES; n++) cell_used[n] = 1'b0;
        live_count = 0;
        res.status = STAT_CLEARED;
      end
      default: res.status = STAT_NOT_FOUND;
    endcase
    res.entry_count = live_count[4:0];
    return res;
  endfunction

  always @(posedge clk) begin : watch
    int        n;
    out_item_t want;
    if (!rst_n) begin
      for (n = 0; n < ENTRIES; n++) cell_used[n] = 1'b0;
      live_count = 0;
      owed_q.delete();
    end else begin
      // check before push, so a result with nothing owed is caught
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got status %0d count %0d",
                   $time, out_item.status, out_item.entry_count);
          fail_total++;
        end else begin
          want = owed_q.pop_front();
          if (out_item.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, out_item.status);
            fail_total++;
          end
          if (out_item.entry_count !== want.entry_count) begin
            $display("%0t: entry_count mismatch: expected %0d, got %0d",
                     $time, want.entry_count, out_item.entry_count);
            fail_total++;
          end
        end
      end
      if (in_valid && in_ready) owed_q.push_back(table_op(in_item));
    end
    mismatch_count <= fail_total;
    results_owed   <= owed_q.size();
  end

endmodule

@@ sim/key_value_table_insert_update_remove_core_tb.sv @@
`timescale 1ns / 100ps

module key_value_table_insert_update_remove_core_tb;
  import kvt_pkg::*;

  localparam int ENTRIES      = 16;
  localparam int RANDOM_ITEMS = 1420;
  localparam int TAIL_ITEMS   = 150;   // last items, sent and taken with no idling
  localparam int STALL_LIMIT  = 2000;  // cycles with no item moving on either side
  localparam int POOL_SIZE    = 24;    // more keys than entries, so the table fills up
  // op code with no name in the package; the block treats it as a lookup miss
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic      clk      = 1'b0;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item  = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int mismatch_count;
  int results_owed;
  int stall_cycles = 0;
  bit steady_tail  = 1'b0;

  // Keys drawn from here most of the time, so updates and removes hit often
  logic signed [31:0] key_pool [POOL_SIZE];

  always #1 clk = ~clk;

  key_value_table_insert_update_remove_core #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  kvt_table_checker #(
    .ENTRIES(ENTRIES)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_item      (out_item),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  // Present one item and hold it until the block takes it. Returns at the
  // edge of acceptance; valid stays high so a following item goes back to back.
  task automatic issue(input logic [1:0] op, input logic signed [31:0] key,
                       input logic signed [31:0] value);
    in_item_t it;
    it.op    = op;
    it.key   = key;
    it.value = value;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic signed [31:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 7) == 0)
      return ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
    return $urandom;
  endfunction

  initial begin : stimulus
    int         i;
    int         n;
    int         r;
    int         add_pct;
    logic [1:0] op;
    for (n = 0; n < POOL_SIZE; n++) key_pool[n] = $urandom;
    // extremes of the key range stay in the pool
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    key_pool[2] = 32'sh0000_0000;
    key_pool[3] = -32'sd1;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // empty table: remove misses, clear still reports, unused op misses
    issue(OP_REMOVE, 32'sd0, 32'sd0);
    issue(OP_CLEAR, 32'sd0, 32'sd0);
    issue(OP_UNUSED, 32'sd0, 32'sd0);
    // inserts with extreme keys and values
    issue(OP_ADD, 32'sh8000_0000, 32'sh7fff_ffff);
    issue(OP_ADD, 32'sh7fff_ffff, 32'sh8000_0000);
    issue(OP_ADD, 32'sd0, 32'sd0);
    issue(OP_ADD, -32'sd1, -32'sd1);
    // update in place, then remove a key twice (hit, then miss)
    issue(OP_ADD, 32'sh8000_0000, 32'sh5555_5555);
    issue(OP_REMOVE, 32'sd0, 32'sd0);
    issue(OP_REMOVE, 32'sd0, 32'sd0);
    // three keys left; fill every remaining entry
    for (n = 0; n < ENTRIES - 3; n++) issue(OP_ADD, 32'sd100 + n, n);
    // full table: new key refused, existing key still updates
    issue(OP_ADD, 32'sd555, 32'shaaaa_aaaa);
    issue(OP_ADD, -32'sd1, 32'sd7);
    issue(OP_UNUSED, 32'sd555, 32'sd0);
    issue(OP_CLEAR, 32'sd0, 32'sd0);

    // --- random part ---
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - TAIL_ITEMS) steady_tail <= 1'b1;
      if (i == RANDOM_ITEMS / 2) begin
        // stop sending until the table has answered every item so far
        in_valid <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
      end else if (!steady_tail && (i / 100) % 3 != 2 && $urandom_range(0, 7) == 0) begin
        // sender gap; every third block of 100 items goes without one
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      if ($urandom_range(0, 63) == 0) key_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
      // alternate fill-heavy and drain-heavy stretches so full and empty both occur
      add_pct = ((i / 200) % 2 == 0) ? 70 : 35;
      r = $urandom_range(0, 99);
      if (r < add_pct) op = OP_ADD;
      else if (r < 96) op = OP_REMOVE;
      else if (r < 98) op = OP_CLEAR;
      else op = OP_UNUSED;
      issue(op, pick_key(), pick_value());
    end

    // drain, then give the block a few cycles to show any stray result
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Receiver: random stall bursts between ready stretches,
  // always ready once the tail starts.
  initial begin : result_side
    @(posedge clk);
    forever begin
      if (!steady_tail && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
